### design/obbw_pkg.sv
// shared constants for the opaque bounding box block: register indexes,
// pass codes and fixed field widths; no dependencies
`default_nettype none

package obbw_pkg;

  localparam int DIM_REG_W = 13;
  localparam int WIN_W     = 16;
  localparam int ALPHA_W   = 8;
  localparam int BOX_W     = 13;
  localparam int PASS_W    = 2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_TOP_DOWN,
    REG_WIN_LEFT,
    REG_WIN_RIGHT,
    REG_WIN_TOP,
    REG_WIN_BOTTOM
  } reg_index_t;

  localparam logic [PASS_W-1:0] PASS_EMPTY  = 2'd0;
  localparam logic [PASS_W-1:0] PASS_TIGHT  = 2'd1;
  localparam logic [PASS_W-1:0] PASS_SHRANK = 2'd2;

endpackage

`default_nettype wire

### design/obbw_clamp.sv
// clamps one signed window bound into [0, dim-1]
// depends on obbw_pkg
`default_nettype none

module obbw_clamp #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic signed [obbw_pkg::WIN_W-1:0] bound,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]      dim,
  output logic [$clog2(MAX_DIM)-1:0]             clamped
);
  import obbw_pkg::*;

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int CMPW = (DW > WIN_W) ? DW : WIN_W;

  logic [CMPW-1:0] bound_u;
  logic [CMPW-1:0] hi_u;

  assign bound_u = CMPW'(bound[WIN_W-2:0]);
  assign hi_u    = CMPW'(DW'(dim - DW'(1)));

  always_comb begin
    if (bound[WIN_W-1]) begin
      clamped = '0;
    end else if (bound_u > hi_u) begin
      clamped = CW'(hi_u);
    end else begin
      clamped = CW'(bound_u);
    end
  end

endmodule

`default_nettype wire

### design/opaque_bounding_box_in_window_unit.sv
// top level of the opaque bounding box block: configuration registers,
// pixel counters, box tracking and result register; depends on obbw_pkg, obbw_clamp
`default_nettype none

// Takes one pixel alpha byte per cycle in memory order and, on the last pixel
// of a frame, sends one result: the tight box around nonzero alpha pixels
// inside the clamped search window plus a pass count. Sustained rate is one
// pixel per clock; a pixel goes through an input register and, on frame end,
// the result register, so the result is offered once the last pixel has passed
// both. The only thing that holds input back is an undelivered result in the
// output register when another frame-ending pixel arrives. The user must write
// registers through the cfg port while no pixel is in flight; the block does not
// enforce it. A write may fall between frames or inside one, the counters carry on.
module opaque_bounding_box_in_window_unit #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [obbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [obbw_pkg::WIN_W-1:0]        cfg_data,
  // pixel stream; tdata: alpha[7:0]
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,
  // result stream; tdata: box_left[12:0], box_right[25:13], box_top[38:26],
  // box_bottom[51:39], pass_count[53:52], zero[55:54]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [55:0]                            m_tdata
);
  import obbw_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  // configuration registers
  logic [DIM_REG_W-1:0]    image_width;
  logic [DIM_REG_W-1:0]    image_height;
  logic                    rows_top_down;
  logic signed [WIN_W-1:0] win_left, win_right, win_top, win_bottom;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DIM_REG_W'(1);
      image_height  <= DIM_REG_W'(1);
      rows_top_down <= 1'b1;
      win_left      <= '0;
      win_right     <= 16'sh7FFF;
      win_top       <= '0;
      win_bottom    <= 16'sh7FFF;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_WIDTH:      image_width   <= cfg_data[DIM_REG_W-1:0];
        REG_HEIGHT:     image_height  <= cfg_data[DIM_REG_W-1:0];
        REG_TOP_DOWN:   rows_top_down <= cfg_data[0];
        REG_WIN_LEFT:   win_left      <= cfg_data;
        REG_WIN_RIGHT:  win_right     <= cfg_data;
        REG_WIN_TOP:    win_top       <= cfg_data;
        REG_WIN_BOTTOM: win_bottom    <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective dimensions: zero acts as one, capped at MAX_DIM
  logic [DW-1:0] w_eff, h_eff, w_m1, h_m1;

  always_comb begin
    if (image_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(image_width) > MAX_DIM) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = DW'(1);
    end else if (32'(image_height) > MAX_DIM) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(image_height);
    end
  end

  assign w_m1 = w_eff - DW'(1);
  assign h_m1 = h_eff - DW'(1);

  logic [CW-1:0] cl, cr, ct, cb;

  obbw_clamp #(.MAX_DIM(MAX_DIM)) u_clamp_left (
    .bound(win_left), .dim(w_eff), .clamped(cl));
  obbw_clamp #(.MAX_DIM(MAX_DIM)) u_clamp_right (
    .bound(win_right), .dim(w_eff), .clamped(cr));
  obbw_clamp #(.MAX_DIM(MAX_DIM)) u_clamp_top (
    .bound(win_top), .dim(h_eff), .clamped(ct));
  obbw_clamp #(.MAX_DIM(MAX_DIM)) u_clamp_bottom (
    .bound(win_bottom), .dim(h_eff), .clamped(cb));

  // input register
  logic               s1_valid;
  logic [ALPHA_W-1:0] s1_alpha;
  logic               advance;

  assign s_tready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_alpha <= s_tdata[ALPHA_W-1:0];
    end
  end

  // frame position and box tracking
  logic [CW-1:0] col_count, row_count;
  logic [CW-1:0] min_col, max_col, min_row, max_row;
  logic          any_opaque;

  logic [CW-1:0] y;
  logic          hit, row_end, frame_end;
  logic [CW-1:0] min_col_next, max_col_next, min_row_next, max_row_next;
  logic          any_opaque_next;

  always_comb begin
    if (rows_top_down) begin
      y = row_count;
    end else if (DW'(row_count) >= h_m1) begin
      y = '0;
    end else begin
      y = CW'(h_m1 - DW'(row_count));
    end
  end

  assign hit = (s1_alpha != '0) && (col_count >= cl) && (col_count <= cr)
               && (y >= ct) && (y <= cb);
  assign row_end   = DW'(col_count) >= w_m1;
  assign frame_end = row_end && (DW'(row_count) >= h_m1);

  always_comb begin
    min_col_next    = min_col;
    max_col_next    = max_col;
    min_row_next    = min_row;
    max_row_next    = max_row;
    any_opaque_next = any_opaque;
    if (hit) begin
      any_opaque_next = 1'b1;
      if (!any_opaque) begin
        min_col_next = col_count;
        max_col_next = col_count;
        min_row_next = y;
        max_row_next = y;
      end else begin
        if (col_count < min_col) min_col_next = col_count;
        if (col_count > max_col) max_col_next = col_count;
        if (y < min_row) min_row_next = y;
        if (y > max_row) max_row_next = y;
      end
    end
  end

  // a frame-ending pixel waits only while the result register is still full
  assign advance = s1_valid && (!frame_end || !m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      any_opaque <= 1'b0;
    end else if (advance) begin
      if (frame_end) begin
        col_count  <= '0;
        row_count  <= '0;
        any_opaque <= 1'b0;
      end else if (row_end) begin
        col_count  <= '0;
        row_count  <= row_count + CW'(1);
        any_opaque <= any_opaque_next;
      end else begin
        col_count  <= col_count + CW'(1);
        any_opaque <= any_opaque_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      min_col <= min_col_next;
      max_col <= max_col_next;
      min_row <= min_row_next;
      max_row <= max_row_next;
    end
  end

  // result
  logic              empty, tight;
  logic [BOX_W-1:0]  box_left, box_right, box_top, box_bottom;
  logic [PASS_W-1:0] pass_count;

  assign empty = (cl > cr) || (ct > cb) || !any_opaque_next;
  assign tight = (min_col_next == cl) && (max_col_next == cr)
                 && (min_row_next == ct) && (max_row_next == cb);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && frame_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_end) begin
      if (empty) begin
        box_left   <= '0;
        box_right  <= '1;
        box_top    <= '0;
        box_bottom <= '1;
        pass_count <= PASS_EMPTY;
      end else begin
        box_left   <= BOX_W'(min_col_next);
        box_right  <= BOX_W'(max_col_next);
        box_top    <= BOX_W'(min_row_next);
        box_bottom <= BOX_W'(max_row_next);
        pass_count <= tight ? PASS_TIGHT : PASS_SHRANK;
      end
    end
  end

  assign m_tdata = {2'b00, pass_count, box_bottom, box_top, box_right, box_left};

  // checks
  a_counters_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && frame_end |=> col_count == '0 && row_count == '0 && !any_opaque)
    else $error("frame counters not cleared after frame end");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    any_opaque |-> min_col <= max_col && min_row <= max_row)
    else $error("tracked box is inverted");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("pending result dropped");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && pass_count == PASS_EMPTY |-> box_left == '0 && box_right == '1
      && box_top == '0 && box_bottom == '1)
    else $error("empty result has wrong box");

  a_pass_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pass_count == PASS_EMPTY || pass_count == PASS_TIGHT
      || pass_count == PASS_SHRANK)
    else $error("reserved pass count");

endmodule

`default_nettype wire
